>>> rtl/fbfa_pkg.sv
package fbfa_pkg;

    // Default geometry of the block table and the pool.
    localparam int DEF_MAX_BLOCKS = 32;
    localparam int DEF_ADDR_BITS  = 16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [1:0] CFG_POOL_BYTES  = 2'd1;
    localparam logic [1:0] CFG_SMALL_LIMIT = 2'd2;

    // Table update operations.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_INIT  = 3'd1,
        OP_MARK  = 3'd2,
        OP_SPLIT = 3'd3,
        OP_MERGE = 3'd4
    } tbl_op_t;

    // Control word from the sequencer to the table.
    typedef struct packed {
        tbl_op_t    op;
        logic [1:0] shift;
    } tbl_ctrl_t;

endpackage

>>> rtl/fbfa_table.sv
module fbfa_table #(
    parameter int MAX_BLOCKS = fbfa_pkg::DEF_MAX_BLOCKS,
    parameter int ADDR_BITS  = fbfa_pkg::DEF_ADDR_BITS,
    localparam int SW    = ADDR_BITS + 1,
    localparam int IDX_W = $clog2(MAX_BLOCKS),
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fbfa_pkg::tbl_ctrl_t   ctrl,
    input  logic [IDX_W-1:0]      pos,
    input  logic [ADDR_BITS-1:0]  start_val,
    input  logic [SW-1:0]         size_a,
    input  logic [SW-1:0]         size_b,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [ADDR_BITS-1:0]  rd_start,
    output logic [SW-1:0]         rd_size,
    output logic                  rd_used,
    output logic [CNT_W-1:0]      count
);

    localparam logic [SW-1:0] POOL_MAX = {1'b1, {ADDR_BITS{1'b0}}};

    logic [ADDR_BITS-1:0] start_reg [MAX_BLOCKS];
    logic [SW-1:0]        size_reg  [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] used_reg;
    logic [CNT_W-1:0]     count_reg;

    // Single read port for the sequencer.
    assign rd_start = start_reg[rd_idx];
    assign rd_size  = size_reg[rd_idx];
    assign rd_used  = used_reg[rd_idx];
    assign count    = count_reg;

    // In a split or a merge, the entries past the update point shift in parallel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= CNT_W'(1);
            used_reg     <= '0;
            start_reg[0] <= '0;
            size_reg[0]  <= POOL_MAX;
        end else begin
            unique case (ctrl.op)
                fbfa_pkg::OP_INIT: begin
                    count_reg    <= CNT_W'(1);
                    used_reg     <= '0;
                    start_reg[0] <= '0;
                    size_reg[0]  <= size_a;
                end
                fbfa_pkg::OP_MARK: begin
                    used_reg[pos] <= 1'b1;
                end
                fbfa_pkg::OP_SPLIT: begin
                    for (int j = 0; j < MAX_BLOCKS; j++) begin
                        if (j == int'(pos)) begin
                            size_reg[j] <= size_a;
                            used_reg[j] <= 1'b1;
                        end else if (j == int'(pos) + 1) begin
                            start_reg[j] <= start_val;
                            size_reg[j]  <= size_b;
                            used_reg[j]  <= 1'b0;
                        end else if (j > int'(pos) + 1) begin
                            start_reg[j] <= start_reg[j-1];
                            size_reg[j]  <= size_reg[j-1];
                            used_reg[j]  <= used_reg[j-1];
                        end
                    end
                    count_reg <= count_reg + CNT_W'(1);
                end
                fbfa_pkg::OP_MERGE: begin
                    for (int j = 0; j < MAX_BLOCKS; j++) begin
                        if (j == int'(pos)) begin
                            size_reg[j] <= size_a;
                            used_reg[j] <= 1'b0;
                        end else if (j > int'(pos) && j + int'(ctrl.shift) < MAX_BLOCKS) begin
                            start_reg[j] <= start_reg[j + int'(ctrl.shift)];
                            size_reg[j]  <= size_reg[j + int'(ctrl.shift)];
                            used_reg[j]  <= used_reg[j + int'(ctrl.shift)];
                        end
                    end
                    count_reg <= count_reg - CNT_W'(ctrl.shift);
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/first_best_fit_allocator.sv
// An accepted request first scans the table entries until it is settled, the table is then
// updated (allocate apply or free merge), a statistics pass runs over the updated table,
// and the result word is loaded. A free of an unknown or already free start skips the
// update, and a zero-size allocate skips the scan. An unread result word stalls the finish.
// Only one request is in flight: a new one is taken only in the idle state.
// Reset (synchronous, active low) leaves one free block spanning the whole pool,
// first fit, and a small limit of zero; no clearing pass is needed.
module first_best_fit_allocator #(
    parameter int MAX_BLOCKS = fbfa_pkg::DEF_MAX_BLOCKS,
    parameter int ADDR_BITS  = fbfa_pkg::DEF_ADDR_BITS,
    localparam int SW    = ADDR_BITS + 1,
    localparam int IDX_W = $clog2(MAX_BLOCKS),
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [SW-1:0]        cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [SW-1:0]        s_request_size,
    input  logic [ADDR_BITS-1:0] s_free_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [ADDR_BITS-1:0] m_granted_address,
    output logic [CNT_W-1:0]     m_hole_count,
    output logic [SW-1:0]        m_allocated_bytes,
    output logic [SW-1:0]        m_free_bytes,
    output logic [SW-1:0]        m_largest_free,
    output logic [CNT_W-1:0]     m_small_free_count
);

    localparam logic [SW-1:0] POOL_MAX = {1'b1, {ADDR_BITS{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FREE_NEXT, S_ALLOC_APPLY, S_STATS, S_FINISH
    } state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 req_type_reg;
    logic [SW-1:0]        req_size_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SW-1:0]        pick_size_reg;
    logic [ADDR_BITS-1:0] pick_start_reg;
    logic                 prev_valid_reg;
    logic                 prev_used_reg;
    logic [SW-1:0]        prev_size_reg;
    fbfa_pkg::status_t    status_reg;
    logic [ADDR_BITS-1:0] gaddr_reg;
    logic [CNT_W-1:0]     holes_reg;
    logic [CNT_W-1:0]     smalls_reg;
    logic [SW-1:0]        used_sum_reg;
    logic [SW-1:0]        largest_reg;
    logic                 fit_mode_reg;
    logic [SW-1:0]        pool_reg;
    logic [SW-1:0]        small_limit_reg;
    logic                 m_valid_reg;
    logic [1:0]           o_status_reg;
    logic [ADDR_BITS-1:0] o_gaddr_reg;
    logic [CNT_W-1:0]     o_holes_reg;
    logic [CNT_W-1:0]     o_smalls_reg;
    logic [SW-1:0]        o_used_reg;
    logic [SW-1:0]        o_free_reg;
    logic [SW-1:0]        o_largest_reg;

    fbfa_pkg::tbl_ctrl_t  ctrl;
    logic [IDX_W-1:0]     tbl_pos;
    logic [ADDR_BITS-1:0] tbl_start;
    logic [SW-1:0]        tbl_size_a;
    logic [SW-1:0]        tbl_size_b;
    logic [IDX_W-1:0]     rd_idx;
    logic [ADDR_BITS-1:0] rd_start;
    logic [SW-1:0]        rd_size;
    logic                 rd_used;
    logic [CNT_W-1:0]     count;

    logic                 last_entry;
    logic                 cand;
    logic                 take;
    logic                 prev_free;
    logic                 next_exists;
    logic                 next_free;
    logic [SW-1:0]        merged_size;
    logic [SW-1:0]        pool_clamped;
    logic                 pool_write;
    fbfa_pkg::status_t    alloc_status;
    fbfa_pkg::tbl_op_t    alloc_op;

    fbfa_table #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .ADDR_BITS (ADDR_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .pos      (tbl_pos),
        .start_val(tbl_start),
        .size_a   (tbl_size_a),
        .size_b   (tbl_size_b),
        .rd_idx   (rd_idx),
        .rd_start (rd_start),
        .rd_size  (rd_size),
        .rd_used  (rd_used),
        .count    (count)
    );

    assign rd_idx     = idx_reg;
    assign last_entry = (CNT_W'(idx_reg) + CNT_W'(1)) == count;

    // Scan decisions for the entry at the read port.
    assign cand = !rd_used && (rd_size >= req_size_reg);
    assign take = cand && (!found_reg || (fit_mode_reg && rd_size < pick_size_reg));

    // Neighbor tests for a merge.
    assign prev_free   = prev_valid_reg && !prev_used_reg;
    assign next_exists = (CNT_W'(pick_reg) + CNT_W'(1)) < count;
    assign next_free   = next_exists && !rd_used;
    assign merged_size = pick_size_reg + (prev_free ? prev_size_reg : '0)
                       + (next_free ? rd_size : '0);

    // Pool size write, clamped to the address range.
    assign pool_write   = cfg_wr_en && (cfg_index == fbfa_pkg::CFG_POOL_BYTES);
    assign pool_clamped = (cfg_data == '0) ? SW'(1) :
                          (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;

    // Outcome of an allocate once the scan has settled.
    always_comb begin
        alloc_status = fbfa_pkg::ST_OK;
        alloc_op     = fbfa_pkg::OP_NONE;
        if (!found_reg) begin
            alloc_status = fbfa_pkg::ST_NOFIT;
        end else if (pick_size_reg == req_size_reg) begin
            alloc_op = fbfa_pkg::OP_MARK;
        end else if (count >= CNT_W'(MAX_BLOCKS)) begin
            alloc_status = fbfa_pkg::ST_FULL;
        end else begin
            alloc_op = fbfa_pkg::OP_SPLIT;
        end
    end

    // Table update command.
    always_comb begin
        ctrl.op    = fbfa_pkg::OP_NONE;
        ctrl.shift = 2'd0;
        tbl_pos    = pick_reg;
        tbl_start  = pick_start_reg + req_size_reg[ADDR_BITS-1:0];
        tbl_size_a = req_size_reg;
        tbl_size_b = pick_size_reg - req_size_reg;
        if (pool_write) begin
            ctrl.op    = fbfa_pkg::OP_INIT;
            tbl_size_a = pool_clamped;
        end else if (state_reg == S_ALLOC_APPLY) begin
            ctrl.op = alloc_op;
        end else if (state_reg == S_FREE_NEXT) begin
            ctrl.op    = fbfa_pkg::OP_MERGE;
            ctrl.shift = {1'b0, prev_free} + {1'b0, next_free};
            tbl_pos    = prev_free ? pick_reg - IDX_W'(1) : pick_reg;
            tbl_size_a = merged_size;
        end
    end

    assign s_ready            = (state_reg == S_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_status           = o_status_reg;
    assign m_granted_address  = o_gaddr_reg;
    assign m_hole_count       = o_holes_reg;
    assign m_allocated_bytes  = o_used_reg;
    assign m_free_bytes       = o_free_reg;
    assign m_largest_free     = o_largest_reg;
    assign m_small_free_count = o_smalls_reg;

    // Sequencer, configuration registers and result word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            fit_mode_reg    <= 1'b0;
            pool_reg        <= POOL_MAX;
            small_limit_reg <= '0;
        end else begin
            // The finish state reloads the result word itself.
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    fbfa_pkg::CFG_FIT_MODE:    fit_mode_reg    <= cfg_data[0];
                    fbfa_pkg::CFG_POOL_BYTES:  pool_reg        <= pool_clamped;
                    fbfa_pkg::CFG_SMALL_LIMIT: small_limit_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_type_reg   <= s_req_type;
                        req_size_reg   <= s_request_size;
                        addr_reg       <= s_free_address;
                        found_reg      <= 1'b0;
                        prev_valid_reg <= 1'b0;
                        idx_reg        <= '0;
                        gaddr_reg      <= '0;
                        holes_reg      <= '0;
                        smalls_reg     <= '0;
                        used_sum_reg   <= '0;
                        largest_reg    <= '0;
                        if (!s_req_type && s_request_size == '0) begin
                            status_reg <= fbfa_pkg::ST_NOFIT;
                            state_reg  <= S_STATS;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!req_type_reg) begin
                        // Allocate: track the chosen free block.
                        if (take) begin
                            found_reg      <= 1'b1;
                            pick_reg       <= idx_reg;
                            pick_size_reg  <= rd_size;
                            pick_start_reg <= rd_start;
                        end
                        if (last_entry || (take && !fit_mode_reg)) begin
                            state_reg <= S_ALLOC_APPLY;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end else if (rd_start == addr_reg) begin
                        // Free: the first block at that start decides.
                        pick_reg      <= idx_reg;
                        pick_size_reg <= rd_size;
                        if (rd_used) begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_FREE_NEXT;
                        end else begin
                            status_reg <= fbfa_pkg::ST_NOTFOUND;
                            idx_reg    <= '0;
                            state_reg  <= S_STATS;
                        end
                    end else begin
                        prev_valid_reg <= 1'b1;
                        prev_used_reg  <= rd_used;
                        prev_size_reg  <= rd_size;
                        if (last_entry) begin
                            status_reg <= fbfa_pkg::ST_NOTFOUND;
                            idx_reg    <= '0;
                            state_reg  <= S_STATS;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                S_FREE_NEXT: begin
                    status_reg <= fbfa_pkg::ST_OK;
                    idx_reg    <= '0;
                    state_reg  <= S_STATS;
                end
                S_ALLOC_APPLY: begin
                    status_reg <= alloc_status;
                    if (alloc_status == fbfa_pkg::ST_OK) begin
                        gaddr_reg <= pick_start_reg;
                    end
                    idx_reg   <= '0;
                    state_reg <= S_STATS;
                end
                S_STATS: begin
                    // Statistics over the updated table, one entry a cycle.
                    if (rd_used) begin
                        used_sum_reg <= used_sum_reg + rd_size;
                    end else begin
                        holes_reg <= holes_reg + CNT_W'(1);
                        if (rd_size > largest_reg) begin
                            largest_reg <= rd_size;
                        end
                        if (rd_size <= small_limit_reg) begin
                            smalls_reg <= smalls_reg + CNT_W'(1);
                        end
                    end
                    if (last_entry) begin
                        state_reg <= S_FINISH;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        o_status_reg  <= status_reg;
                        o_gaddr_reg   <= gaddr_reg;
                        o_holes_reg   <= holes_reg;
                        o_smalls_reg  <= smalls_reg;
                        o_used_reg    <= used_sum_reg;
                        o_free_reg    <= pool_reg - used_sum_reg;
                        o_largest_reg <= largest_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/fbfa_checker.sv
module fbfa_checker #(
    parameter int MAX_BLOCKS = fbfa_pkg::DEF_MAX_BLOCKS,
    parameter int ADDR_BITS  = fbfa_pkg::DEF_ADDR_BITS,
    localparam int SW    = ADDR_BITS + 1,
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_status,
    input logic [ADDR_BITS-1:0] m_granted_address,
    input logic [CNT_W-1:0]     m_hole_count,
    input logic [SW-1:0]        m_largest_free,
    input logic [CNT_W-1:0]     m_small_free_count
);

    // A pending result word is not withdrawn.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped before it was taken");

    // A refused request never reports an address.
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != fbfa_pkg::ST_OK) |-> m_granted_address == '0)
        else $error("address given on a refused request");

    // Small holes are a subset of all holes.
    a_small_holes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_small_free_count <= m_hole_count)
        else $error("more small holes than holes");

    // There is a largest hole exactly when there is any hole.
    a_largest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_hole_count == '0) == (m_largest_free == '0)))
        else $error("largest free size disagrees with hole count");

    // A request keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block ready right after taking a request");

endmodule

bind first_best_fit_allocator fbfa_checker #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS (ADDR_BITS)
) u_fbfa_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_granted_address (m_granted_address),
    .m_hole_count      (m_hole_count),
    .m_largest_free    (m_largest_free),
    .m_small_free_count(m_small_free_count)
);
